[rtl/ansi_sgr_style_filter_macros.svh]
// Assertion macros for the ANSI SGR style filter checker.
// Needs clk and rst_n visible at the point of use.
`ifndef ANSI_SGR_STYLE_FILTER_MACROS_SVH
`define ANSI_SGR_STYLE_FILTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASGR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("asgr: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define ASGR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("asgr: next-cycle check failed");

`endif

[rtl/asgr_pkg.sv]
// Shared types and constants for the ANSI SGR style filter.
// No dependencies.
`timescale 1ns / 1ps

package asgr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COLOUR_W = 4;
    // out_byte, bold, italic, underline, colour = 15 bits, padded to 16
    localparam int unsigned OUT_W    = 16;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_M        = 8'h6D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    localparam logic [7:0] SGR_BOLD_ON       = 8'd1;
    localparam logic [7:0] SGR_ITALIC_ON     = 8'd3;
    localparam logic [7:0] SGR_UNDERLINE_ON  = 8'd4;
    localparam logic [7:0] SGR_BOLD_OFF      = 8'd22;
    localparam logic [7:0] SGR_ITALIC_OFF    = 8'd23;
    localparam logic [7:0] SGR_UNDERLINE_OFF = 8'd24;
    localparam logic [7:0] SGR_COLOUR_FIRST  = 8'd30;
    localparam logic [7:0] SGR_COLOUR_LAST   = 8'd37;
    localparam logic [7:0] SGR_COLOUR_BLACK  = 8'd38;

    localparam logic [COLOUR_W-1:0] COLOUR_BLACK   = 4'd0;
    localparam logic [COLOUR_W-1:0] COLOUR_DEFAULT = 4'd8;

    typedef enum logic [2:0] {
        PH_TEXT  = 3'b001,
        PH_ESC   = 3'b010,
        PH_PARAM = 3'b100
    } phase_t;

    typedef struct packed {
        logic                bold;
        logic                italic;
        logic                underline;
        logic [COLOUR_W-1:0] colour;
    } style_t;

    localparam style_t STYLE_RESET = '{bold: 1'b0, italic: 1'b0, underline: 1'b0,
                                      colour: COLOUR_DEFAULT};

endpackage

[rtl/ansi_sgr_style_filter.sv]
// ANSI SGR style filter: strips ESC [ params m sequences, tags text bytes with style.
// Depends on asgr_pkg.
`timescale 1ns / 1ps

// Takes one byte per clock while the output side takes its requests, and returns
// at most one styled byte per request. A request passes an input register, then
// parser logic that updates the style and loads the output register. Escape bytes
// (ESC, '[', parameters, 'm') produce no output request. The parameter
// accumulator costs one multiply-by-ten adder.
module ansi_sgr_style_filter
    import asgr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] in_byte

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata    // [7:0] out_byte, [8] is_bold, [9] is_italic,
                                           // [10] is_underlined, [14:11] colour, [15] zero
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    style_t            out_style_reg;

    phase_t            phase_reg,     phase_next;
    logic [7:0]        pval_reg,      pval_next;
    logic              pdigit_reg,    pdigit_next;
    logic              pinvalid_reg,  pinvalid_next;
    style_t            style_reg,     style_next;

    logic              advance;
    logic              emit;
    logic              is_digit;
    logic [11:0]       pval_prod;
    logic [7:0]        pval_sat;
    style_t            style_applied;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign is_digit  = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign pval_prod = {1'b0, pval_reg, 3'b000} + {3'b000, pval_reg, 1'b0}
                     + {8'd0, in_byte_reg[3:0]};
    assign pval_sat  = (pval_prod > 12'd255) ? 8'hFF : pval_prod[7:0];

    always_comb
    begin
        style_applied = style_reg;
        if (pinvalid_reg || !pdigit_reg)
        begin
            style_applied = STYLE_RESET;
        end
        else if (pval_reg == SGR_BOLD_ON)
        begin
            style_applied.bold = 1'b1;
        end
        else if (pval_reg == SGR_ITALIC_ON)
        begin
            style_applied.italic = 1'b1;
        end
        else if (pval_reg == SGR_UNDERLINE_ON)
        begin
            style_applied.underline = 1'b1;
        end
        else if (pval_reg == SGR_BOLD_OFF)
        begin
            style_applied.bold = 1'b0;
        end
        else if (pval_reg == SGR_ITALIC_OFF)
        begin
            style_applied.italic = 1'b0;
        end
        else if (pval_reg == SGR_UNDERLINE_OFF)
        begin
            style_applied.underline = 1'b0;
        end
        else if ((pval_reg >= SGR_COLOUR_FIRST) && (pval_reg <= SGR_COLOUR_LAST))
        begin
            style_applied.colour = COLOUR_W'(pval_reg - SGR_COLOUR_FIRST);
        end
        else if (pval_reg == SGR_COLOUR_BLACK)
        begin
            style_applied.colour = COLOUR_BLACK;
        end
        else
        begin
            style_applied = STYLE_RESET;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        pval_next     = pval_reg;
        pdigit_next   = pdigit_reg;
        pinvalid_next = pinvalid_reg;
        style_next    = style_reg;
        emit          = 1'b0;
        unique case (phase_reg)
            PH_PARAM:
            begin
                if (is_digit)
                begin
                    pval_next   = pval_sat;
                    pdigit_next = 1'b1;
                end
                else if (in_byte_reg == CH_SEMI || in_byte_reg == CH_M)
                begin
                    style_next    = style_applied;
                    pval_next     = 8'd0;
                    pdigit_next   = 1'b0;
                    pinvalid_next = 1'b0;
                    if (in_byte_reg == CH_M)
                    begin
                        phase_next = PH_TEXT;
                    end
                end
                else
                begin
                    pinvalid_next = 1'b1;
                end
            end
            PH_ESC, PH_TEXT:
            begin
                if (phase_reg == PH_ESC && in_byte_reg == CH_LBRACKET)
                begin
                    pval_next     = 8'd0;
                    pdigit_next   = 1'b0;
                    pinvalid_next = 1'b0;
                    phase_next    = PH_PARAM;
                end
                else if (in_byte_reg == CH_ESC)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    phase_next = PH_TEXT;
                    emit       = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_TEXT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_TEXT;
            pval_reg      <= 8'd0;
            pdigit_reg    <= 1'b0;
            pinvalid_reg  <= 1'b0;
            style_reg     <= STYLE_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                phase_reg     <= phase_next;
                pval_reg      <= pval_next;
                pdigit_reg    <= pdigit_next;
                pinvalid_reg  <= pinvalid_next;
                style_reg     <= style_next;
                out_valid_reg <= emit;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance && emit)
        begin
            out_byte_reg  <= in_byte_reg;
            out_style_reg <= style_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_style_reg.colour, out_style_reg.underline,
                       out_style_reg.italic, out_style_reg.bold, out_byte_reg};

endmodule

[rtl/asgr_checker.sv]
// Port-level checks for ansi_sgr_style_filter, bound into ansi_sgr_style_filter.
// Depends on asgr_pkg and ansi_sgr_style_filter_macros.svh.
`timescale 1ns / 1ps
`include "ansi_sgr_style_filter_macros.svh"

module asgr_checker
    import asgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata
);

    logic in_req;
    assign in_req = s_tvalid && s_tready && (s_tdata == s_tdata);

    // stalled output request holds
    `ASGR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // the ESC byte never reaches the output
    `ASGR_ASSERT_NOW(a_no_esc_out, m_tvalid, m_tdata[7:0] != CH_ESC)
    // colour index stays within black..default
    `ASGR_ASSERT_NOW(a_colour_range, m_tvalid, m_tdata[14:11] <= COLOUR_DEFAULT)
    // a new output request needs an earlier input request, an earlier output request or a stalled input
    `ASGR_ASSERT_NOW(a_out_cause, $rose(m_tvalid), $past(in_req, 2) || $past(m_tvalid, 2) || !$past(s_tready, 1))

endmodule

bind ansi_sgr_style_filter asgr_checker u_asgr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
